// ----- rtl/bdq_pkg.sv -----
// Shared constants, codes and controller/datapath bundles for the byte deque.
// No dependencies; imported by bdq_ctrl, bdq_dp and byte_deque_core.
`default_nettype none

package bdq_pkg;

    localparam int DEPTH  = 32;
    localparam int PTR_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int DATA_W = 8;
    localparam int FILL_W = 6;

    localparam logic [DATA_W-1:0] EMPTY_MARK = 8'd33;

    localparam logic [1:0] CMD_PUSH_BACK  = 2'd0;
    localparam logic [1:0] CMD_PUSH_FRONT = 2'd1;
    localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [1:0] CMD_POP_BACK   = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       wr_en;
        logic       rd_en;
        logic       at_front;
        logic [1:0] status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic full;
        logic empty;
    } t_dp_status;

endpackage

`default_nettype wire

// ----- rtl/bdq_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module bdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bdq_ctrl.sv -----
// Controller for the byte deque: handshake state machine and command decode.
// Depends on bdq_pkg.
`default_nettype none

module bdq_ctrl
    import bdq_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_stall,
    input  wire logic [1:0] i_cmd,
    output logic            o_out_valid,
    input  wire logic       i_out_stall,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RESP = 1'b1;

    logic r_state;
    logic n_state;
    logic w_accept;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_RESP);
    assign w_accept    = i_in_valid && (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = w_accept;
        o_cmd.status   = ST_OK;
        unique case (i_cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                o_cmd.at_front = (i_cmd == CMD_PUSH_FRONT);
                o_cmd.wr_en    = w_accept && !i_status.full;
                o_cmd.status   = i_status.full ? ST_OVERFLOW : ST_OK;
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                o_cmd.at_front = (i_cmd == CMD_POP_FRONT);
                o_cmd.rd_en    = w_accept && !i_status.empty;
                o_cmd.status   = i_status.empty ? ST_EMPTY : ST_OK;
            end
            default: begin
                o_cmd.status = ST_OK;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a beat accepted always leads to a result on the next cycle
    a_accept_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted beat did not raise output valid");

    // a pending result holds until taken
    a_resp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("stalled result dropped");

    // never write and read the RAM in the same beat
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.wr_en && o_cmd.rd_en))
        else $error("write and read issued together");

endmodule

`default_nettype wire

// ----- rtl/bdq_dp.sv -----
// Datapath for the byte deque: circular buffer pointers, fill count, storage
// RAM and result registers. Depends on bdq_pkg and bdq_ram.
`default_nettype none

module bdq_dp
    import bdq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    input  wire logic [DATA_W-1:0] i_data_in,
    output t_dp_status             o_status,
    output logic      [DATA_W-1:0] o_data_out,
    output logic      [1:0]        o_result_status,
    output logic      [FILL_W-1:0] o_fill_count
);

    logic [PTR_W-1:0]  r_head;
    logic [PTR_W-1:0]  n_head;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic [1:0]        r_status;
    logic              r_pop;
    logic [FILL_W-1:0] r_fill;

    logic [CNT_W-1:0]  w_offset;
    logic [PTR_W:0]    w_sum;
    logic [PTR_W-1:0]  w_back_addr;
    logic [PTR_W-1:0]  w_head_dec;
    logic [PTR_W-1:0]  w_head_inc;
    logic [PTR_W-1:0]  w_addr;
    logic [DATA_W-1:0] w_rd_data;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    // back slot: head + count for a push, head + count - 1 for a pop
    assign w_offset = i_cmd.rd_en ? (r_count - CNT_W'(1)) : r_count;
    assign w_sum    = {1'b0, r_head} + (PTR_W+1)'(w_offset);
    assign w_back_addr = (w_sum >= (PTR_W+1)'(DEPTH))
        ? PTR_W'(w_sum - (PTR_W+1)'(DEPTH)) : PTR_W'(w_sum);

    assign w_head_dec = (r_head == '0) ? PTR_W'(DEPTH - 1) : (r_head - PTR_W'(1));
    assign w_head_inc = (r_head == PTR_W'(DEPTH - 1)) ? '0 : (r_head + PTR_W'(1));

    always_comb begin
        priority if (i_cmd.at_front && i_cmd.wr_en) begin
            w_addr = w_head_dec;
        end else if (i_cmd.at_front) begin
            w_addr = r_head;
        end else begin
            w_addr = w_back_addr;
        end
    end

    always_comb begin
        n_head  = r_head;
        n_count = r_count;
        if (i_cmd.wr_en) begin
            n_count = r_count + CNT_W'(1);
            if (i_cmd.at_front) begin
                n_head = w_head_dec;
            end
        end else if (i_cmd.rd_en) begin
            n_count = r_count - CNT_W'(1);
            if (i_cmd.at_front) begin
                n_head = w_head_inc;
            end
        end
    end

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_rd_en   (i_cmd.rd_en),
        .i_addr    (w_addr),
        .i_wr_data (i_data_in),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // result payload; RAM read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_status <= i_cmd.status;
            r_pop    <= i_cmd.rd_en;
            r_fill   <= FILL_W'(n_count);
        end
    end

    always_comb begin
        priority if (r_pop) begin
            o_data_out = w_rd_data;
        end else if (r_status == ST_EMPTY) begin
            o_data_out = EMPTY_MARK;
        end else begin
            o_data_out = '0;
        end
    end

    assign o_result_status = r_status;
    assign o_fill_count    = r_fill;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count beyond capacity");

    a_count_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_en |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("push did not advance count");

    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.wr_en && !i_cmd.rd_en |=> r_count == $past(r_count) &&
            r_head == $past(r_head))
        else $error("pointers moved without an access");

endmodule

`default_nettype wire

// ----- rtl/byte_deque_core.sv -----
// Byte deque top level: circular buffer in a single-port RAM, head pointer and fill count.
// Result: valid in the cycle after the input beat is accepted.
// Input: the single RAM port and the one-entry result register hold the input stalled
// until the result beat is taken, so no new beat enters while a result is pending.
// Reset: synchronous active-low; clears state and count, RAM contents are undefined.
// Depends on bdq_pkg, bdq_ctrl, bdq_dp and bdq_ram.
`default_nettype none

module byte_deque_core
    import bdq_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_cmd,
    input  wire logic [DATA_W-1:0] i_data_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic      [DATA_W-1:0] o_data_out,
    output logic      [1:0]        o_status,
    output logic      [FILL_W-1:0] o_fill_count
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    bdq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_data_in       (i_data_in),
        .o_status        (w_status),
        .o_data_out      (o_data_out),
        .o_result_status (o_status),
        .o_fill_count    (o_fill_count)
    );

endmodule

`default_nettype wire
